FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/lkvc_pkg.sv
// Types and constants of the LRU key-value cache.
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W   = SLOT_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0] RESET_CAPACITY = CAP_W'(4);

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic [AGE_W-1:0]         age_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef struct packed {
      logic     hit;
      slot_type hit_slot;
      age_type  hit_age;
      word_type hit_value;
      logic     have_free;
      slot_type free_slot;
      slot_type victim_slot;
      cnt_type  count;
   } lookup_type;

   typedef struct packed {
      logic     en;
      logic     set_valid;
      logic     wr_key;
      logic     wr_value;
      slot_type slot;
      cnt_type  limit;
      word_type key;
      word_type value;
   } update_type;

endpackage

FILE: rtl/core/lkvc_store.sv
// Entry registers: valid bits, keys, values and recency ages.
module lkvc_store (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_pkg::update_type  upd,
   output logic                  entry_valid [lkvc_pkg::ENTRIES],
   output lkvc_pkg::word_type    entry_key   [lkvc_pkg::ENTRIES],
   output lkvc_pkg::word_type    entry_value [lkvc_pkg::ENTRIES],
   output lkvc_pkg::age_type     entry_age   [lkvc_pkg::ENTRIES]
);

   logic               valid_ff [lkvc_pkg::ENTRIES];
   logic               valid_in [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type key_ff   [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type key_in   [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type value_ff [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type value_in [lkvc_pkg::ENTRIES];
   lkvc_pkg::age_type  age_ff   [lkvc_pkg::ENTRIES];
   lkvc_pkg::age_type  age_in   [lkvc_pkg::ENTRIES];

   always_comb begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         age_in[i]   = age_ff[i];
         if (upd.en) begin
            if (upd.slot == lkvc_pkg::slot_type'(i)) begin
               age_in[i] = '0;
               if (upd.set_valid) valid_in[i] = 1'b1;
               if (upd.wr_key)    key_in[i]   = upd.key;
               if (upd.wr_value)  value_in[i] = upd.value;
            end else if (valid_ff[i] &&
                         (lkvc_pkg::cnt_type'(age_ff[i]) < upd.limit)) begin
               age_in[i] = lkvc_pkg::age_type'(age_ff[i] + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
         age_ff   <= '{default: '0};
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry_valid = valid_ff;
   assign entry_key   = key_ff;
   assign entry_value = value_ff;
   assign entry_age   = age_ff;

endmodule

FILE: rtl/core/lkvc_lookup.sv
// Parallel key match, free slot, victim slot and fill count.
module lkvc_lookup (
   input  logic                 entry_valid [lkvc_pkg::ENTRIES],
   input  lkvc_pkg::word_type   entry_key   [lkvc_pkg::ENTRIES],
   input  lkvc_pkg::word_type   entry_value [lkvc_pkg::ENTRIES],
   input  lkvc_pkg::age_type    entry_age   [lkvc_pkg::ENTRIES],
   input  lkvc_pkg::word_type   key,
   output lkvc_pkg::lookup_type lk
);

   logic [lkvc_pkg::ENTRIES-1:0] valid_vec;
   lkvc_pkg::cnt_type            count;
   lkvc_pkg::cnt_type            oldest;

   always_comb begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) valid_vec[i] = entry_valid[i];
   end

   assign count  = lkvc_pkg::cnt_type'($countones(valid_vec));
   assign oldest = lkvc_pkg::cnt_type'(count - 1'b1);

   always_comb begin
      lk       = '0;
      lk.count = count;
      // lowest matching and lowest free slot win
      for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid[i] && (entry_key[i] == key)) begin
            lk.hit      = 1'b1;
            lk.hit_slot = lkvc_pkg::slot_type'(i);
         end
         if (!entry_valid[i]) begin
            lk.have_free = 1'b1;
            lk.free_slot = lkvc_pkg::slot_type'(i);
         end
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (entry_valid[i] && (lkvc_pkg::cnt_type'(entry_age[i]) == oldest))
            lk.victim_slot = lkvc_pkg::slot_type'(i);
      end
      lk.hit_age   = entry_age[lk.hit_slot];
      lk.hit_value = entry_value[lk.hit_slot];
   end

endmodule

FILE: rtl/core/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: op; tdata: key, value
//  rsp     | out | rsp_tvalid/rsp_tready | tuser: hit; tdata: read_value
//  csr     | in  | csr_valid/csr_ready   | csr_data: capacity
//
// One request per cycle sustained while rsp is not stalled. The rate is set by the
// combinational match and age update over the register-held entries. Reset clears
// the store, no sweep. A stalled rsp holds one result in the output and one
// request in the input stage.
module lru_key_value_cache_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,  // key[31:0], value[63:32]
   input  logic                          req_tuser,  // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lkvc_pkg::DATA_W-1:0]   rsp_tdata,  // read_value[31:0]
   output logic                          rsp_tuser,  // hit
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_data    // capacity
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   lkvc_pkg::op_type             s1_op_ff;
   lkvc_pkg::word_type           s1_key_ff;
   lkvc_pkg::word_type           s1_value_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_hit_ff;
   logic                         rsp_hit_in;
   lkvc_pkg::word_type           rsp_data_ff;
   lkvc_pkg::word_type           rsp_data_in;
   logic [lkvc_pkg::CAP_W-1:0]   cap_ff;

   logic                         advance;
   logic                         req_xfer;
   logic [lkvc_pkg::LIM_W-1:0]   cap_eff;
   logic                         evict;
   lkvc_pkg::lookup_type         lk;
   lkvc_pkg::update_type         upd;

   logic                         entry_valid [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type           entry_key   [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type           entry_value [lkvc_pkg::ENTRIES];
   lkvc_pkg::age_type            entry_age   [lkvc_pkg::ENTRIES];

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || advance);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      cap_eff = lkvc_pkg::LIM_W'(cap_ff);
      if (cap_eff == '0) cap_eff = lkvc_pkg::LIM_W'(1);
      if (cap_eff > lkvc_pkg::LIM_W'(lkvc_pkg::ENTRIES))
         cap_eff = lkvc_pkg::LIM_W'(lkvc_pkg::ENTRIES);
   end

   lkvc_store u_store (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .entry_valid (entry_valid),
      .entry_key   (entry_key),
      .entry_value (entry_value),
      .entry_age   (entry_age)
   );

   lkvc_lookup u_lookup (
      .entry_valid (entry_valid),
      .entry_key   (entry_key),
      .entry_value (entry_value),
      .entry_age   (entry_age),
      .key         (s1_key_ff),
      .lk          (lk)
   );

   assign evict = (lkvc_pkg::LIM_W'(lk.count) >= cap_eff) || !lk.have_free;

   always_comb begin
      upd       = '0;
      upd.key   = s1_key_ff;
      upd.value = s1_value_ff;
      if (lk.hit) begin
         upd.en       = advance;
         upd.slot     = lk.hit_slot;
         upd.limit    = lkvc_pkg::cnt_type'(lk.hit_age);
         upd.wr_value = (s1_op_ff == lkvc_pkg::OP_PUT);
      end else if (s1_op_ff == lkvc_pkg::OP_PUT) begin
         upd.en       = advance;
         upd.wr_key   = 1'b1;
         upd.wr_value = 1'b1;
         if (evict) begin
            // victim is the oldest, so every other valid entry ages
            upd.slot  = lk.victim_slot;
            upd.limit = lkvc_pkg::cnt_type'(lk.count - 1'b1);
         end else begin
            upd.slot      = lk.free_slot;
            upd.limit     = lk.count;
            upd.set_valid = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_hit_in  = rsp_hit_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_hit_in  = lk.hit;
         rsp_data_in = (lk.hit && (s1_op_ff == lkvc_pkg::OP_GET)) ? lk.hit_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkvc_pkg::RESET_CAPACITY;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) cap_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff    <= lkvc_pkg::op_type'(req_tuser);
         s1_key_ff   <= lkvc_pkg::word_type'(req_tdata[31:0]);
         s1_value_ff <= lkvc_pkg::word_type'(req_tdata[63:32]);
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "assert_macros.svh"

module lkvc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic                        rsp_tuser,
   input logic [lkvc_pkg::DATA_W-1:0] rsp_tdata
);

   `ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_IMPLIES(a_miss_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPLIES(a_rsp_from_req, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

endmodule

bind lru_key_value_cache_unit lkvc_checker u_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key-value cache unit, with its own cache predictor.
module tb_top;

   typedef struct packed {
      logic               hit;
      lkvc_pkg::word_type read_value;
   } cache_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [63:0]                 req_tdata;   // key[31:0], value[63:32]
   logic                        req_tuser;   // op
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [lkvc_pkg::DATA_W-1:0] rsp_tdata;   // read_value[31:0]
   logic                        rsp_tuser;   // hit
   logic                        csr_valid;
   logic                        csr_ready;
   logic [lkvc_pkg::CAP_W-1:0]  csr_data;    // capacity

   lru_key_value_cache_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   logic                       slot_valid [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type         slot_key   [lkvc_pkg::ENTRIES];
   lkvc_pkg::word_type         slot_value [lkvc_pkg::ENTRIES];
   lkvc_pkg::age_type          slot_age   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::CAP_W-1:0] model_capacity;

   cache_result_type pending_results[$];
   int               mismatch_count;
   bit               quiet;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // make slot s most recent; valid slots younger than limit age by one
   function automatic void promote_slot(int s, lkvc_pkg::cnt_type limit);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (slot_valid[i] && i != s && slot_age[i] < limit)
            slot_age[i]++;
      end
      slot_age[s] = '0;
   endfunction

   function automatic cache_result_type cache_access(lkvc_pkg::op_type op,
                                                     lkvc_pkg::word_type k,
                                                     lkvc_pkg::word_type v);
      cache_result_type  r;
      lkvc_pkg::cnt_type eff_cap;
      lkvc_pkg::cnt_type count;
      int                hs;
      int                fs;
      int                vs;
      logic              found;
      logic              have_free;
      lkvc_pkg::age_type oldest;
      r = '0;
      count = '0;
      found = 1'b0;
      have_free = 1'b0;
      oldest = '0;
      hs = 0;
      fs = 0;
      vs = 0;
      eff_cap = lkvc_pkg::cnt_type'(model_capacity);
      if (model_capacity == '0)
         eff_cap = lkvc_pkg::cnt_type'(1);
      else if (model_capacity > lkvc_pkg::ENTRIES)
         eff_cap = lkvc_pkg::cnt_type'(lkvc_pkg::ENTRIES);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (slot_valid[i]) begin
            count++;
            if (!found && slot_key[i] === k) begin
               found = 1'b1;
               hs = i;
            end
            if (slot_age[i] >= oldest) begin
               oldest = slot_age[i];
               vs = i;
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            fs = i;
         end
      end
      r.hit = found;
      if (found) begin
         if (op == lkvc_pkg::OP_PUT)
            slot_value[hs] = v;
         else
            r.read_value = slot_value[hs];
         promote_slot(hs, lkvc_pkg::cnt_type'(slot_age[hs]));
      end else if (op == lkvc_pkg::OP_PUT) begin
         if (count >= eff_cap || !have_free) begin
            slot_key[vs] = k;
            slot_value[vs] = v;
            promote_slot(vs, lkvc_pkg::cnt_type'(slot_age[vs]));
         end else begin
            slot_valid[fs] = 1'b1;
            slot_key[fs] = k;
            slot_value[fs] = v;
            promote_slot(fs, count);
         end
      end
      return r;
   endfunction

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   always @(posedge clock) begin : result_check
      cache_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_results.push_back(cache_access(lkvc_pkg::op_type'(req_tuser),
                                                   req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result transfer hit %0b read_value %0d",
                        $time, rsp_tuser, $signed(rsp_tdata));
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata !== want.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           want.read_value, $signed(rsp_tdata));
                  mismatch_count++;
               end
            end
         end
      end
   end

   // result sink with random stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25)
               stall_left = idle_length();
         end
      end
   end

   task automatic send_request(input lkvc_pkg::op_type op, input lkvc_pkg::word_type k,
                               input lkvc_pkg::word_type v);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 30)
         gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {v, k};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= c;
      do @(posedge clock); while (!csr_ready);
      model_capacity = c;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_lookups();
      send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_fill_and_evict();
      send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0);
      send_request(lkvc_pkg::OP_PUT, 32'h1234_5678, 32'h5A5A_A5A5);  // evicts the oldest
      send_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hDEAD_BEEF);  // update in place
      send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
      send_request(lkvc_pkg::OP_GET, 32'h1234_5678, 32'h0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(5'd0);                                // behaves as one
      send_request(lkvc_pkg::OP_PUT, 32'h0BAD_F00D, 32'h0000_0001);
      send_request(lkvc_pkg::OP_GET, 32'h0BAD_F00D, 32'h0);
      send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0);
      write_capacity(5'd31);                               // clamps to the slot count
      send_request(lkvc_pkg::OP_PUT, 32'hCAFE_0001, 32'hFFFF_FFFE);
      send_request(lkvc_pkg::OP_PUT, 32'hCAFE_0002, 32'h8000_0001);
      send_request(lkvc_pkg::OP_GET, 32'hCAFE_0001, 32'h0);
      send_request(lkvc_pkg::OP_GET, 32'h0BAD_F00D, 32'h0);
   endtask

   task automatic run_traffic(input logic [lkvc_pkg::CAP_W-1:0] cap, input int count,
                              input bit no_idle, input bit pause_midway);
      lkvc_pkg::word_type key_pool[32];
      int                 pool_n;
      int                 eff;
      lkvc_pkg::word_type k;
      lkvc_pkg::word_type v;
      lkvc_pkg::op_type   op;
      write_capacity(cap);
      quiet = no_idle;
      eff = (cap == 0) ? 1 : (cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : cap;
      pool_n = eff + $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++)
         key_pool[i] = $urandom();
      case ($urandom_range(0, 3))
         0: key_pool[0] = 32'h8000_0000;
         1: key_pool[0] = 32'h7FFF_FFFF;
         2: key_pool[0] = 32'hFFFF_FFFF;
         default: key_pool[0] = 32'h0000_0000;
      endcase
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2)
            wait_drained();
         op = lkvc_pkg::op_type'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 88)
            k = key_pool[$urandom_range(0, pool_n - 1)];
         else
            k = $urandom();
         v = $urandom();
         if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         send_request(op, k, v);
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_traffic(5'd1, 150, 1'b0, 1'b1);
      run_traffic(5'd16, 200, 1'b0, 1'b0);
      run_traffic(5'd31, 150, 1'b0, 1'b0);
      run_traffic(5'd2, 150, 1'b0, 1'b0);   // below the count in use
      run_traffic(5'd0, 120, 1'b0, 1'b0);
      run_traffic(5'd9, 150, 1'b1, 1'b0);   // back-to-back, no stalls
      run_traffic(5'd17, 150, 1'b0, 1'b0);
      run_traffic(5'd5, 150, 1'b0, 1'b1);
      repeat (3) run_traffic(5'($urandom_range(1, 16)), 130, 1'b0, 1'b0);
      run_traffic(5'd16, 100, 1'b0, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      quiet = 1'b0;
      mismatch_count = 0;
      model_capacity = lkvc_pkg::RESET_CAPACITY;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_age[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_lookups();
      test_fill_and_evict();
      test_capacity_limits();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
